>>> rtl/acpd_pkg.sv
`timescale 1ns / 1ps
// Package for the ASCII command parser and dispatcher.
// Holds widths, character codes, the command and mode tables and helper functions.
// It has no dependencies.
package acpd_pkg;

    localparam int CHAR_W      = 8;
    localparam int DATA_W      = 32;
    localparam int GEN_W       = 16;
    localparam int ARG_W_DEF   = 32;
    localparam int NUM_CMDS    = 13;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int MODE_MAX    = 11;

    localparam logic [DATA_W-1:0] HZ_STEP         = 32'd390;
    localparam logic [GEN_W-1:0]  GEN_PHASE_RESET = 16'h708a;
    localparam logic [DATA_W-1:0] HZERO_RESET     = 32'h0002fec2;
    localparam logic [3:0]        MODE_NUM_RESET  = 4'd8;

    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_QUERY  = 8'h3f;
    localparam logic [CHAR_W-1:0] CH_QUIT   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_SAVE   = 8'h24;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_STD_SEL = 1'b0;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_DIGITS = 2'd2
    } t_parse_phase;

    typedef enum logic [3:0] {
        CMD_GS   = 4'd0,
        CMD_GM   = 4'd1,
        CMD_GI   = 4'd2,
        CMD_GJ   = 4'd3,
        CMD_GZ   = 4'd4,
        CMD_GY   = 4'd5,
        CMD_GA   = 4'd6,
        CMD_GF   = 4'd7,
        CMD_GG   = 4'd8,
        CMD_GD   = 4'd9,
        CMD_GE   = 4'd10,
        CMD_SW   = 4'd11,
        CMD_DU   = 4'd12,
        CMD_NONE = 4'd13
    } t_cmd_idx;

    typedef enum logic [2:0] {
        UPD_NONE   = 3'd0,
        UPD_GEN_G  = 3'd1,
        UPD_GEN_M  = 3'd2,
        UPD_GEN_D6 = 3'd3,
        UPD_GEN_D5 = 3'd4,
        UPD_HZ_G   = 3'd5,
        UPD_HZ_M   = 3'd6,
        UPD_MODE   = 3'd7
    } t_upd_reg;

    // Letter pairs in table order, first letter in the upper byte.
    localparam logic [15:0] CMD_TABLE [NUM_CMDS] = '{
        16'h4753, 16'h474d, 16'h4749, 16'h474a, 16'h475a, 16'h4759, 16'h4741,
        16'h4746, 16'h4747, 16'h4744, 16'h4745, 16'h5357, 16'h4455
    };

    function automatic logic [7:0] mode_bits_of(input logic [3:0] num);
        logic [7:0] bits;
        case (num)
            4'd0:    bits = 8'h21;
            4'd1:    bits = 8'h0f;
            4'd2:    bits = 8'h0d;
            4'd3:    bits = 8'h05;
            4'd4:    bits = 8'h05;
            4'd5:    bits = 8'h04;
            4'd6:    bits = 8'h11;
            4'd7:    bits = 8'h01;
            4'd8:    bits = 8'h41;
            4'd9:    bits = 8'h10;
            4'd10:   bits = 8'h40;
            4'd11:   bits = 8'h00;
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic logic is_letter_or_query(input logic [CHAR_W-1:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || is_lower(c) || (c == CH_QUERY);
    endfunction

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        return is_lower(c) ? (c - CASE_DIFF) : c;
    endfunction

endpackage

>>> rtl/acpd_in_if.sv
`timescale 1ns / 1ps
// Input channel of the command parser: one received character per transfer.
// Depends on acpd_pkg for the field widths.
interface acpd_in_if;
    import acpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;
    logic [DATA_W-1:0] h_input;

    modport source (output valid, output rx_char, output h_input, input ready);
    modport sink   (input valid, input rx_char, input h_input, output ready);
endinterface

>>> rtl/acpd_out_if.sv
`timescale 1ns / 1ps
// Result channel of the command parser: one transfer per completed command.
// Depends on acpd_pkg for the field types and widths.
interface acpd_out_if;
    import acpd_pkg::*;

    logic              valid;
    logic              ready;
    t_cmd_idx          command_index;
    logic [DATA_W-1:0] number_value;
    logic              query_flag;
    logic              quit_flag;
    logic              save_flag;
    t_upd_reg          updated_register;
    logic [DATA_W-1:0] updated_value;
    logic [7:0]        mode_bits;
    logic              mode_error;

    modport source (
        output valid, output command_index, output number_value, output query_flag,
        output quit_flag, output save_flag, output updated_register,
        output updated_value, output mode_bits, output mode_error, input ready
    );
    modport sink (
        input valid, input command_index, input number_value, input query_flag,
        input quit_flag, input save_flag, input updated_register,
        input updated_value, input mode_bits, input mode_error, output ready
    );
endinterface

>>> rtl/ascii_command_parser_dispatch.sv
`timescale 1ns / 1ps
// ASCII command parser and dispatcher: top level.
// Depends on acpd_pkg, acpd_in_if, acpd_out_if and acpd_cmd_match.
//
// Usage:
//   Characters arrive as transfers on the input channel (rx_char with the
//   measured h_input). Two letters pick a command, decimal digits build its
//   argument and a terminator (LF, '?', '!', '$') completes it. A
//   terminator after the two letters yields exactly one transfer on the
//   result channel with the matched command, the argument, the terminator
//   flags and any register update; all other characters yield nothing.
//   An accepted terminator passes through the input register and then the
//   result register. One character is accepted every cycle while results
//   are taken; the rate is set by the combinational decode and update between them.
//   When the receiver stalls, one further character is held in the input
//   register and input ready drops until the waiting result is taken.
//   Reset (synchronous, active low) clears the parser, restores the phase
//   and mode registers to their defaults and sets standard_select to 1.
//   standard_select is at APB byte address 0; writes complete in the access
//   cycle, pready is always high and reads return the register.
module ascii_command_parser_dispatch #(
    parameter int ARG_WIDTH = acpd_pkg::ARG_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    acpd_in_if.sink                         in_ch,
    acpd_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [acpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [acpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [acpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import acpd_pkg::*;

    // Configuration register.
    logic r_std_sel;
    logic reg_hit;

    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_STD_SEL);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(APB_DATA_W-1){1'b0}}, r_std_sel} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std_sel <= 1'b1;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_std_sel <= pwdata[0];
        end
    end

    // Input register.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic [DATA_W-1:0] r_hin;
    logic              advance;
    logic              item_go;

    assign advance     = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = !r_in_valid || advance;
    assign item_go     = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_in_valid <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_char <= in_ch.rx_char;
            r_hin  <= in_ch.h_input;
        end
    end

    // Parser and register state.
    t_parse_phase         r_phase, n_phase;
    logic [CHAR_W-1:0]    r_first, n_first;
    logic [CHAR_W-1:0]    r_second, n_second;
    logic [ARG_WIDTH-1:0] r_acc, n_acc;
    logic [GEN_W-1:0]     r_gen [4];
    logic [GEN_W-1:0]     n_gen [4];
    logic [DATA_W-1:0]    r_hz [2];
    logic [DATA_W-1:0]    n_hz [2];
    logic [3:0]           r_mode_num, n_mode_num;
    logic [7:0]           r_mode_bits, n_mode_bits;

    t_cmd_idx          match_idx;
    logic              res_fire;
    t_upd_reg          upd_reg;
    logic [DATA_W-1:0] upd_val;
    logic              merr;
    logic [DATA_W-1:0] arg32;
    logic              is_digit;
    logic              is_term;
    logic              sel;

    acpd_cmd_match u_match (
        .i_first  (r_first),
        .i_second (r_second),
        .o_index  (match_idx)
    );

    assign arg32    = 32'(r_acc);
    assign is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign is_term  = (r_char == CH_LF) || (r_char == CH_QUERY) ||
                      (r_char == CH_QUIT) || (r_char == CH_SAVE);
    assign sel      = !r_std_sel;

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_second    = r_second;
        n_acc       = r_acc;
        n_gen       = r_gen;
        n_hz        = r_hz;
        n_mode_num  = r_mode_num;
        n_mode_bits = r_mode_bits;
        res_fire    = 1'b0;
        upd_reg     = UPD_NONE;
        upd_val     = '0;
        merr        = 1'b0;
        case (r_phase)
            PH_FIRST: begin
                if (is_letter_or_query(r_char)) begin
                    n_first = fold_upper(r_char);
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (is_letter_or_query(r_char)) begin
                    n_second = fold_upper(r_char);
                    n_acc    = '0;
                    n_phase  = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) +
                            {{(ARG_WIDTH-4){1'b0}}, r_char[3:0]};
                end
                // A terminator is never a digit, so the stored argument is final here.
                if (is_term) begin
                    n_phase  = PH_FIRST;
                    res_fire = 1'b1;
                    case (match_idx)
                        CMD_GM: begin
                            if (r_acc > ARG_WIDTH'(MODE_MAX)) begin
                                merr = 1'b1;
                            end else begin
                                n_mode_num  = r_acc[3:0];
                                n_mode_bits = mode_bits_of(r_acc[3:0]);
                                upd_reg     = UPD_MODE;
                                upd_val     = {28'd0, r_acc[3:0]};
                            end
                        end
                        CMD_GI: begin
                            n_hz[0] = r_hz[0] + HZ_STEP;
                            upd_reg = UPD_HZ_G;
                            upd_val = n_hz[0];
                        end
                        CMD_GJ: begin
                            n_hz[1] = r_hz[1] + HZ_STEP;
                            upd_reg = UPD_HZ_M;
                            upd_val = n_hz[1];
                        end
                        CMD_GZ: begin
                            n_hz[0] = arg32;
                            upd_reg = UPD_HZ_G;
                            upd_val = arg32;
                        end
                        CMD_GY: begin
                            n_hz[1] = arg32;
                            upd_reg = UPD_HZ_M;
                            upd_val = arg32;
                        end
                        CMD_GA: begin
                            n_hz[sel] = r_hin - {16'd0, r_gen[{1'b0, sel}]};
                            upd_reg   = sel ? UPD_HZ_M : UPD_HZ_G;
                            upd_val   = n_hz[sel];
                        end
                        CMD_GF: begin
                            n_gen[0] = arg32[GEN_W-1:0];
                            upd_reg  = UPD_GEN_G;
                            upd_val  = {16'd0, arg32[GEN_W-1:0]};
                        end
                        CMD_GG: begin
                            n_gen[1] = arg32[GEN_W-1:0];
                            upd_reg  = UPD_GEN_M;
                            upd_val  = {16'd0, arg32[GEN_W-1:0]};
                        end
                        CMD_GD: begin
                            n_gen[2] = arg32[GEN_W-1:0];
                            upd_reg  = UPD_GEN_D6;
                            upd_val  = {16'd0, arg32[GEN_W-1:0]};
                        end
                        CMD_GE: begin
                            n_gen[3] = arg32[GEN_W-1:0];
                            upd_reg  = UPD_GEN_D5;
                            upd_val  = {16'd0, arg32[GEN_W-1:0]};
                        end
                        default: begin
                            upd_reg = UPD_NONE;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_first     <= '0;
            r_second    <= '0;
            r_acc       <= '0;
            r_gen[0]    <= GEN_PHASE_RESET;
            r_gen[1]    <= GEN_PHASE_RESET;
            r_gen[2]    <= '0;
            r_gen[3]    <= '0;
            r_hz[0]     <= HZERO_RESET;
            r_hz[1]     <= HZERO_RESET;
            r_mode_num  <= MODE_NUM_RESET;
            r_mode_bits <= '0;
        end else if (item_go) begin
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_second    <= n_second;
            r_acc       <= n_acc;
            r_gen       <= n_gen;
            r_hz        <= n_hz;
            r_mode_num  <= n_mode_num;
            r_mode_bits <= n_mode_bits;
        end
    end

    // Result register: emptied when taken, loaded by a terminator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.valid <= 1'b0;
        end else if (advance) begin
            out_ch.valid <= r_in_valid && res_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_go && res_fire) begin
            out_ch.command_index    <= match_idx;
            out_ch.number_value     <= arg32;
            out_ch.query_flag       <= (r_char == CH_QUERY);
            out_ch.quit_flag        <= (r_char == CH_QUIT);
            out_ch.save_flag        <= (r_char == CH_SAVE);
            out_ch.updated_register <= upd_reg;
            out_ch.updated_value    <= upd_val;
            out_ch.mode_bits        <= n_mode_bits;
            out_ch.mode_error       <= merr;
        end
    end
endmodule

>>> rtl/acpd_cmd_match.sv
`timescale 1ns / 1ps
// Command table lookup: matches the stored letter pair against the command table.
// Depends on acpd_pkg for the table and the index type.
module acpd_cmd_match (
    input  logic [acpd_pkg::CHAR_W-1:0] i_first,
    input  logic [acpd_pkg::CHAR_W-1:0] i_second,
    output acpd_pkg::t_cmd_idx          o_index
);
    import acpd_pkg::*;

    // Walk the table from the end so that the earliest matching entry wins.
    always_comb begin
        o_index = CMD_NONE;
        for (int k = NUM_CMDS - 1; k >= 0; k--) begin
            if (CMD_TABLE[k] == {i_first, i_second}) begin
                o_index = t_cmd_idx'(4'(k));
            end
        end
    end
endmodule

>>> verif/tb_ascii_command_parser_dispatch.sv
`timescale 1ns / 1ps
// Self-checking testbench for ascii_command_parser_dispatch: character transfers in, command
// reports out, checked against a behavioural parser kept inside this file.
// Depends on acpd_pkg, acpd_in_if, acpd_out_if and the block itself.
module tb_ascii_command_parser_dispatch;
    import acpd_pkg::*;

    localparam int          LIMIT_CYCLES  = 400_000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          PHASE_CHARS   = 300;
    localparam int          OPENING_LEN   = 26;
    localparam logic [31:0] HZERO_STEP    = 32'd390;
    localparam logic [31:0] MODE_LIMIT    = 32'd11;

    localparam logic [APB_ADDR_W-1:0] STD_SEL_ADDR = APB_ADDR_W'(4 * REG_STD_SEL);

    localparam logic [15:0] COMMAND_PAIRS [13] = '{
        "GS", "GM", "GI", "GJ", "GZ", "GY", "GA", "GF", "GG", "GD", "GE", "SW", "DU"
    };
    localparam logic [7:0] MODE_BIT_TABLE [12] = '{
        8'h21, 8'h0f, 8'h0d, 8'h05, 8'h05, 8'h04, 8'h11, 8'h01, 8'h41, 8'h10, 8'h40, 8'h00
    };
    localparam logic [7:0] TERMINATORS [4] = '{CH_LF, CH_QUERY, CH_QUIT, CH_SAVE};
    localparam int PHASE_IDLE_PCT [4] = '{20, 0, 35, 10};

    typedef struct packed {
        t_cmd_idx    command_index;
        logic [31:0] number_value;
        logic        query_flag;
        logic        quit_flag;
        logic        save_flag;
        t_upd_reg    updated_register;
        logic [31:0] updated_value;
        logic [7:0]  mode_bits;
        logic        mode_error;
    } t_report;

    typedef struct packed {
        logic [7:0]  ch;
        logic [31:0] h;
        logic        typed;
        t_report     want;
    } t_row;

    // Opening sequence; the typed reports are the ones that follow directly from reset.
    localparam t_row OPENING [OPENING_LEN] = '{
        '{8'h00, 32'h0000_0000, 1'b0, '0},
        '{8'hff, 32'hffff_ffff, 1'b0, '0},
        '{"g",   32'h0000_0001, 1'b0, '0},
        '{"m",   32'h0000_0002, 1'b0, '0},
        '{"1",   32'h0000_0003, 1'b0, '0},
        '{"2",   32'h0000_0004, 1'b0, '0},
        '{CH_QUIT, 32'h0000_0005, 1'b1,
          '{CMD_GM, 32'd12, 1'b0, 1'b1, 1'b0, UPD_NONE, 32'd0, 8'h00, 1'b1}},
        '{"G",   32'h1234_5678, 1'b0, '0},
        '{"a",   32'h8765_4321, 1'b0, '0},
        '{CH_LF, 32'hffff_ffff, 1'b1,
          '{CMD_GA, 32'd0, 1'b0, 1'b0, 1'b0, UPD_HZ_G, 32'hffff_8f75, 8'h00, 1'b0}},
        '{"G",   32'h0000_0000, 1'b0, '0},
        '{"I",   32'h0000_0000, 1'b0, '0},
        '{CH_SAVE, 32'h0000_0000, 1'b0, '0},
        '{"x",   32'h5555_5555, 1'b0, '0},
        '{"y",   32'haaaa_aaaa, 1'b0, '0},
        '{8'hff, 32'h0000_0000, 1'b0, '0},
        '{"q",   32'h0000_0000, 1'b0, '0},
        '{CH_QUERY, 32'h0000_0000, 1'b1,
          '{CMD_NONE, 32'd0, 1'b1, 1'b0, 1'b0, UPD_NONE, 32'd0, 8'h00, 1'b0}},
        '{"G",   32'h0000_0000, 1'b0, '0},
        '{"f",   32'h0000_0000, 1'b0, '0},
        '{"9",   32'h0000_0000, 1'b0, '0},
        '{CH_LF, 32'h0000_0000, 1'b0, '0},
        '{"G",   32'h0000_0000, 1'b0, '0},
        '{"M",   32'h0000_0000, 1'b0, '0},
        '{"7",   32'h0000_0000, 1'b0, '0},
        '{CH_SAVE, 32'h0000_0000, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    acpd_in_if  char_ch ();
    acpd_out_if report_ch ();

    ascii_command_parser_dispatch u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (char_ch),
        .out_ch  (report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state as the block should hold it.
    t_parse_phase parse_state   = PH_FIRST;
    logic [7:0]   first_char    = 8'd0;
    logic [7:0]   second_char   = 8'd0;
    logic [31:0]  argument      = 32'd0;
    logic [15:0]  gen_phase [4] = '{16'd28810, 16'd28810, 16'd0, 16'd0};
    logic [31:0]  hzero [2]     = '{32'd196290, 32'd196290};
    logic [3:0]   mode_num      = 4'd8;
    logic [7:0]   mode_bits_now = 8'd0;
    logic         std_sel       = 1'b1;

    t_report reports_due [$];
    int      mismatches = 0;
    int      chars_sent = 0;
    int      idle_pct   = 25;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic letter_like(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_QUERY;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    // Advances the parser by one character; returns 1 when a command report is due.
    function automatic logic parse_character(input logic [7:0] c, input logic [31:0] h,
                                             output t_report r);
        int slot;
        int sel;
        r = '0;
        case (parse_state)
            PH_FIRST: begin
                if (letter_like(c)) begin
                    first_char  = to_upper(c);
                    parse_state = PH_SECOND;
                end
                return 1'b0;
            end
            PH_SECOND: begin
                if (letter_like(c)) begin
                    second_char = to_upper(c);
                    parse_state = PH_DIGITS;
                    argument    = 32'd0;
                end
                return 1'b0;
            end
            PH_DIGITS: ;
            default: begin
                parse_state = PH_FIRST;
                return 1'b0;
            end
        endcase

        if (c >= CH_ZERO && c <= CH_NINE)
            argument = argument * 32'd10 + 32'(c - CH_ZERO);
        if (!(c == CH_LF || c == CH_QUERY || c == CH_QUIT || c == CH_SAVE))
            return 1'b0;

        parse_state = PH_FIRST;
        r.command_index = CMD_NONE;
        for (int k = 0; k < 13; k++) begin
            if (COMMAND_PAIRS[k] == {first_char, second_char} && r.command_index == CMD_NONE)
                r.command_index = t_cmd_idx'(k);
        end
        r.number_value = argument;
        r.query_flag   = (c == CH_QUERY);
        r.quit_flag    = (c == CH_QUIT);
        r.save_flag    = (c == CH_SAVE);
        sel            = std_sel ? 0 : 1;

        case (r.command_index)
            CMD_GM: begin
                if (argument > MODE_LIMIT) begin
                    r.mode_error = 1'b1;
                end else begin
                    mode_num           = argument[3:0];
                    mode_bits_now      = MODE_BIT_TABLE[mode_num];
                    r.updated_register = UPD_MODE;
                    r.updated_value    = 32'(mode_num);
                end
            end
            CMD_GI, CMD_GJ: begin
                slot               = int'(r.command_index) - int'(CMD_GI);
                hzero[slot]        = hzero[slot] + HZERO_STEP;
                r.updated_register = t_upd_reg'(int'(UPD_HZ_G) + slot);
                r.updated_value    = hzero[slot];
            end
            CMD_GZ, CMD_GY: begin
                slot               = int'(r.command_index) - int'(CMD_GZ);
                hzero[slot]        = argument;
                r.updated_register = t_upd_reg'(int'(UPD_HZ_G) + slot);
                r.updated_value    = argument;
            end
            CMD_GA: begin
                hzero[sel]         = h - 32'(gen_phase[sel]);
                r.updated_register = t_upd_reg'(int'(UPD_HZ_G) + sel);
                r.updated_value    = hzero[sel];
            end
            CMD_GF, CMD_GG, CMD_GD, CMD_GE: begin
                slot               = int'(r.command_index) - int'(CMD_GF);
                gen_phase[slot]    = argument[15:0];
                r.updated_register = t_upd_reg'(int'(UPD_GEN_G) + slot);
                r.updated_value    = 32'(gen_phase[slot]);
            end
            default: ;
        endcase
        r.mode_bits = mode_bits_now;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    function automatic logic [31:0] pick_h();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 26) == 26) ? CH_QUERY : 8'(CH_UP_A + $urandom_range(0, 25));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic [31:0] h, input logic typed,
                             input t_report want);
        t_report predicted;
        logic    made;
        if ($urandom_range(0, 99) < idle_pct) begin
            repeat ($urandom_range(1, 11)) begin
                @(negedge i_clk);
                char_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        char_ch.valid   <= 1'b1;
        char_ch.rx_char <= c;
        char_ch.h_input <= h;
        do @(posedge i_clk); while (char_ch.ready !== 1'b1);
        chars_sent++;
        made = parse_character(c, h, predicted);
        if (made)
            reports_due.push_back(typed ? want : predicted);
    endtask

    task automatic send_noise_maybe();
        if ($urandom_range(0, 11) == 0)
            send_char(8'($urandom_range(0, 255)), pick_h(), 1'b0, '0);
    endtask

    // One command, mostly well formed, with stray bytes now and then.
    task automatic send_command();
        logic [15:0] pair;
        logic [7:0]  letter;
        int          n;
        int          ndig;
        if ($urandom_range(0, 15) < 13)
            pair = COMMAND_PAIRS[$urandom_range(0, 12)];
        else
            pair = {rand_letter(), rand_letter()};

        for (int i = 0; i < 2; i++) begin
            letter = (i == 0) ? pair[15:8] : pair[7:0];
            if ($urandom_range(0, 1) == 1)
                letter = letter | 8'h20;
            send_noise_maybe();
            send_char(letter, pick_h(), 1'b0, '0);
        end

        if (pair == "GM" && $urandom_range(0, 7) != 0) begin
            // Mode numbers near the table edge, with a leading zero now and then.
            n = $urandom_range(0, 19);
            if ($urandom_range(0, 5) == 0)
                send_char(CH_ZERO, pick_h(), 1'b0, '0);
            if (n >= 10)
                send_char(8'(CH_ZERO + 1), pick_h(), 1'b0, '0);
            send_char(8'(CH_ZERO + n % 10), pick_h(), 1'b0, '0);
        end else begin
            ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
            repeat (ndig) begin
                send_noise_maybe();
                send_char(8'(CH_ZERO + $urandom_range(0, 9)), pick_h(), 1'b0, '0);
            end
        end
        send_noise_maybe();
        send_char(TERMINATORS[$urandom_range(0, 3)], pick_h(), 1'b0, '0);
    endtask

    // Holds the sender off until every outstanding report has been received.
    task automatic drain();
        @(negedge i_clk);
        char_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_standard_select(input logic val);
        logic [31:0] word;
        word = ($urandom & ~32'h1) | 32'(val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STD_SEL_ADDR;
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        std_sel = val;
        // Read the register back straight away.
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        check_field("standard_select", 32'(val), 32'(prdata[0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: ready drops in bursts while idling is enabled.
    initial begin : report_sink
        int stall_left;
        stall_left      = 0;
        report_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                report_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                report_ch.ready <= 1'b1;
                if ($urandom_range(0, 399) < idle_pct)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge i_clk) begin : report_watch
        t_report want;
        if (i_rst_n === 1'b1 && report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
            if (reports_due.size() == 0) begin
                $error("report transfer with no command outstanding");
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("command_index", 32'(want.command_index),
                            32'(report_ch.command_index));
                check_field("number_value", want.number_value, report_ch.number_value);
                check_field("query_flag", 32'(want.query_flag), 32'(report_ch.query_flag));
                check_field("quit_flag", 32'(want.quit_flag), 32'(report_ch.quit_flag));
                check_field("save_flag", 32'(want.save_flag), 32'(report_ch.save_flag));
                check_field("updated_register", 32'(want.updated_register),
                            32'(report_ch.updated_register));
                check_field("updated_value", want.updated_value, report_ch.updated_value);
                check_field("mode_bits", 32'(want.mode_bits), 32'(report_ch.mode_bits));
                check_field("mode_error", 32'(want.mode_error), 32'(report_ch.mode_error));
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int total;
        i_rst_n         = 1'b0;
        char_ch.valid   = 1'b0;
        char_ch.rx_char = 8'd0;
        char_ch.h_input = 32'd0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        total           = OPENING_LEN + 4 * PHASE_CHARS;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[i])
            send_char(OPENING[i].ch, OPENING[i].h, OPENING[i].typed, OPENING[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_standard_select(ph[0]);
            idle_pct = PHASE_IDLE_PCT[ph];
            while (chars_sent < OPENING_LEN + (ph + 1) * PHASE_CHARS) begin
                // The tail of the run goes at full rate on both sides.
                if (chars_sent > total - 200)
                    idle_pct = 0;
                send_command();
            end
        end

        drain();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/acpd_pkg.sv
rtl/acpd_in_if.sv
rtl/acpd_out_if.sv
rtl/acpd_cmd_match.sv
rtl/ascii_command_parser_dispatch.sv
verif/tb_ascii_command_parser_dispatch.sv
